/* rtl/bmpu_pkg.sv */
// shared types, codes and constants of the bmp pixel unpacker
package bmpu_pkg;

  localparam int MaxDimensionDef = 4096;
  localparam int PaletteDepthDef = 256;

  localparam int CfgDataW = 13;
  localparam int CfgDimW  = 13;
  localparam int PalCntW  = 9;
  localparam int InDataW  = 40;
  localparam int OutDataW = 48;
  localparam int PosW     = 12;
  localparam int RgbW     = 24;

  localparam int OqDepth = 4;
  localparam int OqAw    = $clog2(OqDepth);

  typedef enum logic [2:0] {
    FMT_1BPP  = 3'd0,
    FMT_4BPP  = 3'd1,
    FMT_8BPP  = 3'd2,
    FMT_24BPP = 3'd3,
    FMT_32BPP = 3'd4
  } pix_fmt_e;

  typedef enum logic [1:0] {
    REG_FORMAT    = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_PAL_COUNT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]         fmt;
    logic [CfgDimW-1:0] width;
    logic [CfgDimW-1:0] height;
    logic [PalCntW-1:0] pal_count;
  } cfg_t;

  typedef struct packed {
    logic            lookup;
    logic [RgbW-1:0] rgb;
    logic [PosW-1:0] column;
    logic [PosW-1:0] row;
    logic            last;
    logic            eoi;
  } pix_req_t;

  typedef struct packed {
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [PosW-1:0] column;
    logic [PosW-1:0] row;
    logic            last;
    logic            eoi;
  } pix_out_t;

endpackage

/* rtl/bmpu_ram.sv */
// generic single-port ram with registered read
module bmpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bmpu_seq.sv */
// input register and per-byte pixel sequencer with row and column tracking
module bmpu_seq #(
  parameter int MAX_DIMENSION = bmpu_pkg::MaxDimensionDef,
  parameter int PALETTE_DEPTH = bmpu_pkg::PaletteDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bmpu_pkg::cfg_t                   cfg_i,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  input  logic                             s_op_i,
  input  logic [bmpu_pkg::InDataW-1:0]     s_data_i,
  input  logic                             credit_i,
  output logic                             ram_we_o,
  output logic                             ram_re_o,
  output logic [$clog2(PALETTE_DEPTH)-1:0] ram_addr_o,
  output logic [bmpu_pkg::RgbW-1:0]        ram_wdata_o,
  output logic                             req_vld_o,
  output bmpu_pkg::pix_req_t               req_o
);
  import bmpu_pkg::*;

  localparam int CW = $clog2(MAX_DIMENSION + 1);
  localparam int XW = (CW > CfgDimW) ? CW : CfgDimW;
  localparam int BW = CW + 5;
  localparam int RW = CW + 3;
  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [XW-1:0] MaxDim = XW'(MAX_DIMENSION);
  localparam logic [PalCntW-1:0] PalDepth = PalCntW'(PALETTE_DEPTH);

  logic            item_vld_q, item_vld_d;
  logic [2:0]      sub_q, sub_d;
  logic [CW-1:0]   column_q, column_d;
  logic [CW-1:0]   row_q, row_d;
  logic [RW-1:0]   rbc_q, rbc_d;
  logic [15:0]     asm_q, asm_d;
  logic [1:0]      phase_q, phase_d;
  logic            op_q;
  logic [7:0]      byte_q;
  logic [7:0]      pidx_q;
  logic [RgbW-1:0] prgb_q;

  logic [XW-1:0]   wx, hx;
  logic [CW-1:0]   w, h;
  logic [BW-1:0]   bits;
  logic [BW:0]     stride_sum;
  logic [RW-1:0]   stride, rbc_inc;
  logic [CW:0]     col_inc, row_inc;
  logic            col_ok, col_last, row_last;
  logic            emit, lookup, last_px, byte_end, supported;
  logic [7:0]      idx;
  logic [PalCntW-1:0] idx_ext;
  logic [AW-1:0]   rd_addr;
  logic            step, done, accept;

  // dimension clamp and row stride in bytes
  always_comb begin
    wx = XW'(cfg_i.width);
    hx = XW'(cfg_i.height);
    if (wx == '0) begin
      w = CW'(1);
    end else if (wx > MaxDim) begin
      w = CW'(MAX_DIMENSION);
    end else begin
      w = CW'(wx);
    end
    if (hx == '0) begin
      h = CW'(1);
    end else if (hx > MaxDim) begin
      h = CW'(MAX_DIMENSION);
    end else begin
      h = CW'(hx);
    end
    unique case (pix_fmt_e'(cfg_i.fmt))
      FMT_1BPP:  bits = BW'(w);
      FMT_4BPP:  bits = BW'(w) << 2;
      FMT_8BPP:  bits = BW'(w) << 3;
      FMT_24BPP: bits = (BW'(w) << 4) + (BW'(w) << 3);
      FMT_32BPP: bits = BW'(w) << 5;
      default:   bits = '0;
    endcase
    stride_sum = (BW + 1)'(bits) + (BW + 1)'(31);
    stride     = {stride_sum[BW:5], 2'b00};
  end

  assign col_inc  = (CW + 1)'(column_q) + (CW + 1)'(1);
  assign row_inc  = (CW + 1)'(row_q) + (CW + 1)'(1);
  assign col_ok   = column_q < w;
  assign col_last = col_inc >= (CW + 1)'(w);
  assign row_last = row_inc >= (CW + 1)'(h);
  assign rbc_inc  = rbc_q + RW'(1);

  // pixel of the current sub-step
  always_comb begin
    emit      = 1'b0;
    lookup    = 1'b1;
    idx       = byte_q;
    last_px   = 1'b1;
    byte_end  = 1'b1;
    supported = 1'b1;
    phase_d   = phase_q;
    asm_d     = asm_q;
    unique case (pix_fmt_e'(cfg_i.fmt))
      FMT_1BPP: begin
        emit     = col_ok;
        idx      = {7'd0, byte_q[3'd7 - sub_q]};
        last_px  = (sub_q == 3'd7) || col_last;
        byte_end = !col_ok || last_px;
      end
      FMT_4BPP: begin
        emit     = col_ok;
        idx      = sub_q[0] ? {4'd0, byte_q[3:0]} : {4'd0, byte_q[7:4]};
        last_px  = sub_q[0] || col_last;
        byte_end = !col_ok || last_px;
      end
      FMT_8BPP: begin
        emit = col_ok;
      end
      FMT_24BPP, FMT_32BPP: begin
        lookup = 1'b0;
        if (col_ok) begin
          if (phase_q == 2'd0) begin
            asm_d   = {8'd0, byte_q};
            phase_d = 2'd1;
          end else if (phase_q == 2'd1) begin
            asm_d   = {byte_q, asm_q[7:0]};
            phase_d = 2'd2;
          end else if (phase_q == 2'd2 || pix_fmt_e'(cfg_i.fmt) == FMT_24BPP) begin
            emit    = 1'b1;
            phase_d = (pix_fmt_e'(cfg_i.fmt) == FMT_32BPP) ? 2'd3 : 2'd0;
          end else begin
            phase_d = 2'd0;
          end
        end
      end
      default: begin
        supported = 1'b0;
      end
    endcase
  end

  // out-of-palette indices read entry zero
  always_comb begin
    idx_ext = PalCntW'(idx);
    if (idx_ext < cfg_i.pal_count && idx_ext < PalDepth) begin
      rd_addr = AW'(idx);
    end else begin
      rd_addr = '0;
    end
  end

  assign step       = item_vld_q && (op_q || credit_i);
  assign done       = step && (op_q || byte_end);
  assign s_tready_o = !item_vld_q || done;
  assign accept     = s_tvalid_i && s_tready_o;

  assign ram_we_o    = item_vld_q && op_q && (PalCntW'(pidx_q) < PalDepth);
  assign ram_addr_o  = op_q ? AW'(pidx_q) : rd_addr;
  assign ram_wdata_o = prgb_q;
  assign req_vld_o   = step && !op_q && emit;
  assign ram_re_o    = req_vld_o && lookup;

  assign req_o.lookup = lookup;
  assign req_o.rgb    = {byte_q, asm_q[15:8], asm_q[7:0]};
  assign req_o.column = PosW'(column_q);
  assign req_o.row    = PosW'(row_q);
  assign req_o.last   = last_px;
  assign req_o.eoi    = row_last && (col_inc == (CW + 1)'(w));

  always_comb begin
    item_vld_d = item_vld_q;
    sub_d      = sub_q;
    column_d   = column_q;
    row_d      = row_q;
    rbc_d      = rbc_q;
    if (done) begin
      item_vld_d = 1'b0;
    end
    if (accept) begin
      item_vld_d = 1'b1;
    end
    if (step && !op_q && supported) begin
      column_d = column_q + CW'(emit);
      sub_d    = byte_end ? 3'd0 : sub_q + 3'd1;
      if (byte_end) begin
        if (rbc_inc >= stride) begin
          rbc_d    = '0;
          column_d = '0;
          row_d    = row_last ? '0 : CW'(row_inc);
        end else begin
          rbc_d = rbc_inc;
        end
      end
    end else if (done) begin
      sub_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      sub_q      <= '0;
      column_q   <= '0;
      row_q      <= '0;
      rbc_q      <= '0;
      asm_q      <= '0;
      phase_q    <= '0;
    end else begin
      item_vld_q <= item_vld_d;
      sub_q      <= sub_d;
      column_q   <= column_d;
      row_q      <= row_d;
      rbc_q      <= rbc_d;
      if (step && !op_q && supported) begin
        if (byte_end && rbc_inc >= stride) begin
          asm_q   <= '0;
          phase_q <= '0;
        end else begin
          asm_q   <= asm_d;
          phase_q <= phase_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_op_i;
      byte_q <= s_data_i[7:0];
      pidx_q <= s_data_i[15:8];
      prgb_q <= {s_data_i[23:16], s_data_i[31:24], s_data_i[39:32]};
    end
  end

endmodule

/* rtl/bmpu_out.sv */
// palette read stage and output queue with issue credit
module bmpu_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_vld_i,
  input  bmpu_pkg::pix_req_t        req_i,
  input  logic [bmpu_pkg::RgbW-1:0] ram_rdata_i,
  output logic                      credit_o,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output bmpu_pkg::pix_out_t        m_px_o
);
  import bmpu_pkg::*;

  logic                pipe_vld_q;
  pix_req_t            pipe_q;
  pix_out_t            fifo_q [OqDepth];
  logic [OqAw-1:0]     wptr_q, rptr_q;
  logic [OqAw:0]       cnt_q, occ;
  logic [RgbW-1:0]     rgb;
  pix_out_t            entry;
  logic                push, pop;

  assign rgb   = pipe_q.lookup ? ram_rdata_i : pipe_q.rgb;
  assign entry = '{red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
                   column: pipe_q.column, row: pipe_q.row,
                   last: pipe_q.last, eoi: pipe_q.eoi};

  assign push       = pipe_vld_q;
  assign m_tvalid_o = cnt_q != '0;
  assign pop        = m_tvalid_o && m_tready_i;
  assign m_px_o     = fifo_q[rptr_q];

  // room for everything in flight plus one more beat
  assign occ      = cnt_q + (OqAw + 1)'(pipe_vld_q);
  assign credit_o = occ < (OqAw + 1)'(OqDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= 1'b0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      cnt_q      <= '0;
    end else begin
      pipe_vld_q <= req_vld_i;
      if (push) begin
        wptr_q <= wptr_q + OqAw'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + OqAw'(1);
      end
      cnt_q <= cnt_q + (OqAw + 1)'(push) - (OqAw + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_i) begin
      pipe_q <= req_i;
    end
    if (push) begin
      fifo_q[wptr_q] <= entry;
    end
  end

endmodule

/* rtl/bmp_pixel_unpacker.sv */
// top level of the bmp pixel unpacker: config registers, sequencer, palette, output queue
//
//  port group   dir  beat contents
//  s_axis       in   tuser op, tdata data/palette entry
//  m_axis       out  tdata pixel and position, tlast last of byte, tuser end of image
//  cfg          in   register index, write data
//
// a byte yields up to two pixels at 4 bpp and up to eight at 1 bpp; pixel bytes and padding
// bytes wait for output queue credit while palette writes do not; one pixel per cycle, while
// credit is granted, through the single palette read port; a new byte is taken as the last one completes
// a pixel passes the input register, the palette read stage and the output queue in turn
// palette contents are undefined after reset, no clearing pass
// a stalled output fills a four-beat queue, then input stalls
module bmp_pixel_unpacker #(
  parameter int MAX_DIMENSION = bmpu_pkg::MaxDimensionDef,
  parameter int PALETTE_DEPTH = bmpu_pkg::PaletteDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_byte, palette_index, palette_red, palette_green, palette_blue
  input  logic [bmpu_pkg::InDataW-1:0]  s_axis_tdata,
  // op
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // red, green, blue, column, row
  output logic [bmpu_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  // end_of_image
  output logic                          m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [bmpu_pkg::CfgDataW-1:0] cfg_data_i
);
  import bmpu_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  cfg_t            cfg_q;
  logic            credit;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_addr;
  logic [RgbW-1:0] ram_wdata, ram_rdata;
  logic            req_vld;
  pix_req_t        req;
  pix_out_t        px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt       <= FMT_24BPP;
      cfg_q.width     <= CfgDimW'(1);
      cfg_q.height    <= CfgDimW'(1);
      cfg_q.pal_count <= PalCntW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FORMAT:    cfg_q.fmt       <= cfg_data_i[2:0];
        REG_WIDTH:     cfg_q.width     <= cfg_data_i[CfgDimW-1:0];
        REG_HEIGHT:    cfg_q.height    <= cfg_data_i[CfgDimW-1:0];
        REG_PAL_COUNT: cfg_q.pal_count <= cfg_data_i[PalCntW-1:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  bmpu_seq #(
    .MAX_DIMENSION(MAX_DIMENSION),
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_op_i     (s_axis_tuser),
    .s_data_i   (s_axis_tdata),
    .credit_i   (credit),
    .ram_we_o   (ram_we),
    .ram_re_o   (ram_re),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata),
    .req_vld_o  (req_vld),
    .req_o      (req)
  );

  bmpu_ram #(
    .WIDTH(RgbW),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  bmpu_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_vld_i  (req_vld),
    .req_i      (req),
    .ram_rdata_i(ram_rdata),
    .credit_o   (credit),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_px_o     (px)
  );

  assign m_axis_tdata = {px.row, px.column, px.blue, px.green, px.red};
  assign m_axis_tlast = px.last;
  assign m_axis_tuser = px.eoi;

endmodule
